// File: hw/rtl/ips_patch_stream_parser_macros.svh
// Assertion macros shared by the IPS patch stream parser RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef IPS_PATCH_STREAM_PARSER_MACROS_SVH
`define IPS_PATCH_STREAM_PARSER_MACROS_SVH

// Implication checked in the same cycle.
`define IPSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define IPSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/ipsp_pkg.sv
// Package for the IPS patch stream parser: phase type, result codes, constants
// and the state and result structures. Depends on nothing.
package ipsp_pkg;

   localparam int unsigned ByteW     = 8;
   localparam int unsigned OffsetW   = 24;
   localparam int unsigned AddrW     = 25;
   localparam int unsigned LenW      = 16;
   localparam int unsigned CountW    = 3;
   localparam int unsigned KindW     = 2;
   localparam int unsigned RspDataW  = 56;

   localparam logic [OffsetW-1:0] EofMark   = 24'h454F46;
   localparam logic [CountW-1:0]  HeaderLen = 3'd5;
   localparam logic [CountW-1:0]  OffsetLen = 3'd3;
   localparam logic [CountW-1:0]  SizeLen   = 3'd2;

   localparam logic [KindW-1:0] KIND_LITERAL = 2'd0;
   localparam logic [KindW-1:0] KIND_RUN     = 2'd1;
   localparam logic [KindW-1:0] KIND_END     = 2'd2;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_OFFSET   = 3'd1,
      PH_SIZE     = 3'd2,
      PH_RUNCOUNT = 3'd3,
      PH_RUNVAL   = 3'd4,
      PH_DATA     = 3'd5,
      PH_DONE     = 3'd6
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic [CountW-1:0]    field_count;
      logic [OffsetW-1:0]   offset;
      logic [LenW-1:0]      length;
      logic [LenW-1:0]      index;
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic [KindW-1:0]     kind;
      logic [AddrW-1:0]     address;
      logic [LenW-1:0]      run_count;
      logic [ByteW-1:0]     value;
      logic                 last;
   } result_type;

endpackage

// File: hw/rtl/ipsp_step.sv
// Per-byte parsing step of the IPS patch stream parser: next state and result.
// Depends on ipsp_pkg.
module ipsp_step (
   input  ipsp_pkg::state_type          state_cur,
   input  logic [ipsp_pkg::ByteW-1:0]   patch_byte,
   input  logic                         file_start,
   output ipsp_pkg::state_type          state_next,
   output ipsp_pkg::result_type         result
);
   import ipsp_pkg::*;

   state_type           cur;
   logic [CountW-1:0]   count_inc;
   logic [OffsetW-1:0]  offset_shift;
   logic [LenW-1:0]     length_shift;
   logic                data_last;

   always_comb begin
      if (file_start) begin
         cur = '{phase: PH_HEADER, field_count: '0, offset: '0, length: '0, index: '0};
      end else begin
         cur = state_cur;
      end
   end

   assign count_inc    = cur.field_count + 3'd1;
   assign offset_shift = {cur.offset[OffsetW-ByteW-1:0], patch_byte};
   assign length_shift = {cur.length[LenW-ByteW-1:0], patch_byte};
   assign data_last    = ({1'b0, cur.index} + 17'd1) >= {1'b0, cur.length};

   always_comb begin
      state_next = cur;
      case (cur.phase)
         PH_HEADER: begin
            state_next.field_count = count_inc;
            if (count_inc >= HeaderLen) begin
               state_next.phase       = PH_OFFSET;
               state_next.field_count = '0;
               state_next.offset      = '0;
            end
         end
         PH_OFFSET: begin
            state_next.offset      = offset_shift;
            state_next.field_count = count_inc;
            if (count_inc >= OffsetLen) begin
               state_next.field_count = '0;
               if (offset_shift == EofMark) begin
                  state_next.phase = PH_DONE;
               end else begin
                  state_next.length = '0;
                  state_next.phase  = PH_SIZE;
               end
            end
         end
         PH_SIZE: begin
            state_next.length      = length_shift;
            state_next.field_count = count_inc;
            if (count_inc >= SizeLen) begin
               state_next.field_count = '0;
               if (length_shift == '0) begin
                  state_next.phase = PH_RUNCOUNT;
               end else begin
                  state_next.index = '0;
                  state_next.phase = PH_DATA;
               end
            end
         end
         PH_RUNCOUNT: begin
            state_next.length      = length_shift;
            state_next.field_count = count_inc;
            if (count_inc >= SizeLen) begin
               state_next.field_count = '0;
               state_next.phase       = PH_RUNVAL;
            end
         end
         PH_RUNVAL: begin
            state_next.phase       = PH_OFFSET;
            state_next.field_count = '0;
            state_next.offset      = '0;
         end
         PH_DATA: begin
            if (data_last) begin
               state_next.phase       = PH_OFFSET;
               state_next.field_count = '0;
               state_next.offset      = '0;
               state_next.index       = '0;
            end else begin
               state_next.index = cur.index + 16'd1;
            end
         end
         default: begin
            state_next.phase = PH_DONE;
         end
      endcase
   end

   always_comb begin
      result = '0;
      case (cur.phase)
         PH_OFFSET: begin
            if (count_inc >= OffsetLen && offset_shift == EofMark) begin
               result.valid = 1'b1;
               result.kind  = KIND_END;
            end
         end
         PH_RUNVAL: begin
            if (cur.length != '0) begin
               result.valid     = 1'b1;
               result.kind      = KIND_RUN;
               result.address   = {1'b0, cur.offset};
               result.run_count = cur.length;
               result.value     = patch_byte;
               result.last      = 1'b1;
            end
         end
         PH_DATA: begin
            result.valid   = 1'b1;
            result.kind    = KIND_LITERAL;
            result.address = {1'b0, cur.offset} + {9'd0, cur.index};
            result.value   = patch_byte;
            result.last    = data_last;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// File: hw/rtl/ips_patch_stream_parser.sv
// Top level of the IPS patch stream parser: parser state, stream handshake and
// result register. Depends on ipsp_pkg, ipsp_step and the assertion macros.
//
//   Channel   Direction   Item
//   req_      in          one patch file byte, tuser marks the start of a file
//   rsp_      out         one write, run fill or end marker
//
// Every accepted byte is parsed in the cycle it is taken; its result, if any,
// appears in the result register in the next cycle. One byte per cycle flows if
// results drain; the result register is the only stage between the two sides.
// A stalled result holds the input only while the register is full and not
// taken. Reset clears the parser to the header phase and empties the output.
`include "ips_patch_stream_parser_macros.svh"

module ips_patch_stream_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] patch_byte
   input  logic                            req_tuser,  // [0] file_start
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [24:0] target_address, [40:25] run_count, [48:41] byte_value, [55:49] zero
   output logic [ipsp_pkg::RspDataW-1:0]   rsp_tdata,
   output logic [ipsp_pkg::KindW-1:0]      rsp_tuser,  // [1:0] result_kind
   output logic                            rsp_tlast   // record_last
);
   import ipsp_pkg::*;

   state_type    state_ff, state_in, state_step;
   result_type   result;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic [KindW-1:0]    rsp_kind_ff, rsp_kind_in;
   logic         rsp_last_ff, rsp_last_in;
   logic         req_accept;

   ipsp_step u_step (
      .state_cur  (state_ff),
      .patch_byte (req_tdata),
      .file_start (req_tuser),
      .state_next (state_step),
      .result     (result)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_accept) begin
         state_in     = state_step;
         rsp_valid_in = result.valid;
         rsp_data_in  = {{(RspDataW - AddrW - LenW - ByteW){1'b0}},
                         result.value, result.run_count, result.address};
         rsp_kind_in  = result.kind;
         rsp_last_in  = result.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{phase: PH_HEADER, field_count: '0, offset: '0,
                           length: '0, index: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `IPSP_ASSERT_NOW(a_end_clean, clock, reset, rsp_tvalid && rsp_tuser == KIND_END, rsp_tdata == '0 && !rsp_tlast, "end marker result carries nonzero fields")
   `IPSP_ASSERT_NOW(a_run_shape, clock, reset, rsp_tvalid && rsp_tuser == KIND_RUN, rsp_tlast && rsp_tdata[40:25] != '0, "run result without last flag or with zero count")
   `IPSP_ASSERT_NOW(a_literal_count, clock, reset, rsp_tvalid && rsp_tuser == KIND_LITERAL, rsp_tdata[40:25] == '0, "literal result with nonzero run count")
   `IPSP_ASSERT_NEXT(a_done_after_end, clock, reset, req_accept && result.valid && result.kind == KIND_END, state_ff.phase == PH_DONE, "parser not finished after end marker")

endmodule
